// ===== hdl/acsp_pkg.sv =====
// Shared constants for the adaptive chunk size policy block.
package acsp_pkg;

    // Default number of chunk scale steps (1024 bytes down to 16 bytes).
    localparam int NUM_SCALES_DEFAULT = 7;

    // Field widths fixed by the transaction format.
    localparam int RUN_W      = 16;
    localparam int TOTAL_W    = 36;
    localparam int BYTES_W    = 11;
    localparam int RANDOM_W   = 15;
    localparam int POLICY_W   = 3;
    localparam int START_W    = 3;

    // Configuration port geometry: 64-bit data, registers on 8-byte strides.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    // Register indexes.
    localparam logic [2:0] REG_STARTING_SCALE    = 3'd0;
    localparam logic [2:0] REG_SUCCESS_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_FAIL_THRESHOLD    = 3'd2;
    localparam logic [2:0] REG_SCALING_POLICY    = 3'd3;
    localparam logic [2:0] REG_TOTAL_WORKLOAD    = 3'd4;

    // Scaling policy codes; anything above POLICY_LINEAR_ADAPTIVE is invalid.
    localparam logic [POLICY_W-1:0] POLICY_NONE            = 3'd0;
    localparam logic [POLICY_W-1:0] POLICY_LINEAR          = 3'd1;
    localparam logic [POLICY_W-1:0] POLICY_RANDOM          = 3'd2;
    localparam logic [POLICY_W-1:0] POLICY_RANDOM_ADAPTIVE = 3'd3;
    localparam logic [POLICY_W-1:0] POLICY_LINEAR_ADAPTIVE = 3'd4;

    // Operation codes of an input transaction.
    localparam logic OP_START = 1'b0;
    localparam logic OP_CHUNK = 1'b1;

    // Register reset values.
    localparam logic [START_W-1:0]  STARTING_SCALE_RESET    = 3'd0;
    localparam logic [RUN_W-1:0]    SUCCESS_THRESHOLD_RESET = 16'd2;
    localparam logic [RUN_W-1:0]    FAIL_THRESHOLD_RESET    = 16'd2;
    localparam logic [POLICY_W-1:0] SCALING_POLICY_RESET    = POLICY_LINEAR;
    localparam logic [TOTAL_W-1:0]  TOTAL_WORKLOAD_RESET    = 36'd5242880;

    // Largest chunk, at scale index zero.
    localparam logic [BYTES_W-1:0] MAX_CHUNK_BYTES = 11'd1024;

endpackage

// ===== hdl/adaptive_chunk_size_policy.sv =====
// Top level of the adaptive chunk size policy block.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ---------------------------------------
//  in        sink       in_valid / in_stall       operation, power_lost, random_value
//  out       source     out_valid / out_stall     scale_index, next_chunk_bytes,
//                                                 bytes_credited, bytes_total,
//                                                 workload_done, invalid_policy
//  cfg       slave      psel / penable / pready   paddr, pwdata, pwrite, prdata
//
// Each input transaction produces exactly one output transaction. The block is a
// two-register pipeline: an input register that already holds the random value
// folded into a small weighted sum, and a result register loaded together with
// the run state. A new transaction is accepted in every cycle while in_stall is low,
// and its result is presented from the result register once the update stage advances.
// Reset clears the run state and both valid flags and restores the configuration
// registers to their default values.
// A stalled result holds the result register; the input register still takes one
// more transaction, after which in_stall follows out_stall.
module adaptive_chunk_size_policy
#(
    parameter int NUM_SCALES = acsp_pkg::NUM_SCALES_DEFAULT,
    parameter int SCALE_W    = $clog2(NUM_SCALES)
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    // Input channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic                                power_lost,
    input  logic [acsp_pkg::RANDOM_W-1:0]       random_value,

    // Output channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [SCALE_W-1:0]                  scale_index,
    output logic [acsp_pkg::BYTES_W-1:0]        next_chunk_bytes,
    output logic [acsp_pkg::BYTES_W-1:0]        bytes_credited,
    output logic [acsp_pkg::TOTAL_W-1:0]        bytes_total,
    output logic                                workload_done,
    output logic                                invalid_policy,

    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [acsp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [acsp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [acsp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import acsp_pkg::*;

    // The random pick is random_value mod NUM_SCALES. Each bit of the random value
    // contributes (2^i mod NUM_SCALES); the sum of those weights is small and is
    // reduced to the final residue by a short compare and subtract chain.
    localparam int SUM_MAX = RANDOM_W * (NUM_SCALES - 1);
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    // The reduction works at a width that holds NUM_SCALES (at most 4 bits)
    // shifted by up to SUM_W - 1 places.
    localparam int RED_W   = SUM_W + 4;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [START_W-1:0]  starting_scale_reg;
    logic [RUN_W-1:0]    success_threshold_reg;
    logic [RUN_W-1:0]    fail_threshold_reg;
    logic [POLICY_W-1:0] scaling_policy_reg;
    logic [TOTAL_W-1:0]  total_workload_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            starting_scale_reg    <= STARTING_SCALE_RESET;
            success_threshold_reg <= SUCCESS_THRESHOLD_RESET;
            fail_threshold_reg    <= FAIL_THRESHOLD_RESET;
            scaling_policy_reg    <= SCALING_POLICY_RESET;
            total_workload_reg    <= TOTAL_WORKLOAD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_STARTING_SCALE:    starting_scale_reg    <= pwdata[START_W-1:0];
                REG_SUCCESS_THRESHOLD: success_threshold_reg <= pwdata[RUN_W-1:0];
                REG_FAIL_THRESHOLD:    fail_threshold_reg    <= pwdata[RUN_W-1:0];
                REG_SCALING_POLICY:    scaling_policy_reg    <= pwdata[POLICY_W-1:0];
                REG_TOTAL_WORKLOAD:    total_workload_reg    <= pwdata[TOTAL_W-1:0];
                default:               ;
            endcase
        end
    end

    // Read data is a plain mux on the register index.
    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            REG_STARTING_SCALE:    prdata = CFG_DATA_W'(starting_scale_reg);
            REG_SUCCESS_THRESHOLD: prdata = CFG_DATA_W'(success_threshold_reg);
            REG_FAIL_THRESHOLD:    prdata = CFG_DATA_W'(fail_threshold_reg);
            REG_SCALING_POLICY:    prdata = CFG_DATA_W'(scaling_policy_reg);
            REG_TOTAL_WORKLOAD:    prdata = CFG_DATA_W'(total_workload_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input stage: fold the random value into a weighted residue sum
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] rnd_weight [RANDOM_W];

    for (genvar gi = 0; gi < RANDOM_W; gi++)
    begin : g_weight
        localparam int BitWeight = (1 << gi) % NUM_SCALES;
        assign rnd_weight[gi] = random_value[gi] ? SUM_W'(BitWeight) : '0;
    end

    logic [SUM_W-1:0] rnd_sum;

    always_comb
    begin
        rnd_sum = '0;
        for (int i = 0; i < RANDOM_W; i++)
        begin
            rnd_sum = rnd_sum + rnd_weight[i];
        end
    end

    logic             in_valid_reg;
    logic             in_valid_next;
    logic             op_reg;
    logic             lost_reg;
    logic [SUM_W-1:0] rnd_sum_reg;

    logic load_in;
    logic advance;

    // The update stage fires when it holds a transaction and the result
    // register is free or being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign load_in  = in_valid && !in_stall;

    always_comb
    begin
        if (load_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            op_reg      <= operation;
            lost_reg    <= power_lost;
            rnd_sum_reg <= rnd_sum;
        end
    end

    // ------------------------------------------------------------------
    // Update stage: residue reduction, counters, policy and byte total
    // ------------------------------------------------------------------
    logic [RED_W-1:0]   rnd_mod;
    logic [SCALE_W-1:0] rnd_scale;

    // Restoring reduction of the weighted sum by shifted copies of NUM_SCALES.
    always_comb
    begin
        rnd_mod = RED_W'(rnd_sum_reg);
        for (int k = SUM_W - 1; k >= 0; k--)
        begin
            if (rnd_mod >= (RED_W'(NUM_SCALES) << k))
            begin
                rnd_mod = rnd_mod - (RED_W'(NUM_SCALES) << k);
            end
        end
    end

    assign rnd_scale = SCALE_W'(rnd_mod);

    logic [SCALE_W-1:0] scale_reg;
    logic [SCALE_W-1:0] scale_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [RUN_W-1:0]   fail_run_reg;
    logic [RUN_W-1:0]   fail_run_next;
    logic [RUN_W-1:0]   success_run_reg;
    logic [RUN_W-1:0]   success_run_next;

    logic [SCALE_W-1:0] start_scale;
    logic [BYTES_W-1:0] cur_bytes;
    logic [BYTES_W-1:0] credited;
    logic [TOTAL_W:0]   total_sum;
    logic               invalid;
    logic               fail_hit;
    logic               success_hit;
    logic               at_smallest;
    logic               at_largest;

    // Starting scale clamps to the smallest chunk.
    always_comb
    begin
        if (int'(starting_scale_reg) > NUM_SCALES - 1)
        begin
            start_scale = SCALE_W'(NUM_SCALES - 1);
        end
        else
        begin
            start_scale = SCALE_W'(starting_scale_reg);
        end
    end

    assign cur_bytes   = MAX_CHUNK_BYTES >> scale_reg;
    assign invalid     = scaling_policy_reg > POLICY_LINEAR_ADAPTIVE;
    assign at_smallest = int'(scale_reg) >= NUM_SCALES - 1;
    assign at_largest  = scale_reg == '0;

    always_comb
    begin
        scale_next       = scale_reg;
        total_next       = total_reg;
        fail_run_next    = fail_run_reg;
        success_run_next = success_run_reg;
        credited         = '0;
        total_sum        = '0;
        fail_hit         = 1'b0;
        success_hit      = 1'b0;

        if (op_reg == OP_START)
        begin
            scale_next    = start_scale;
            total_next    = '0;
            fail_run_next = '0;
        end
        else
        begin
            // Record the chunk outcome first; the policy sees the updated runs.
            if (!lost_reg)
            begin
                credited  = cur_bytes;
                total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(cur_bytes);
                if (total_sum[TOTAL_W])
                begin
                    total_next = '1;
                end
                else
                begin
                    total_next = total_sum[TOTAL_W-1:0];
                end
                fail_run_next = '0;
                if (success_run_reg != '1)
                begin
                    success_run_next = success_run_reg + 1'b1;
                end
            end
            else
            begin
                success_run_next = '0;
                if (fail_run_reg != '1)
                begin
                    fail_run_next = fail_run_reg + 1'b1;
                end
            end

            fail_hit    = fail_run_next >= fail_threshold_reg;
            success_hit = success_run_next >= success_threshold_reg;

            case (scaling_policy_reg)
                POLICY_LINEAR:
                begin
                    if (fail_hit)
                    begin
                        fail_run_next = '0;
                        if (!at_smallest)
                        begin
                            scale_next = scale_reg + 1'b1;
                        end
                    end
                end
                POLICY_RANDOM:
                begin
                    if (fail_hit)
                    begin
                        fail_run_next = '0;
                        scale_next    = rnd_scale;
                    end
                end
                POLICY_RANDOM_ADAPTIVE:
                begin
                    if (fail_hit)
                    begin
                        fail_run_next = '0;
                        scale_next    = rnd_scale;
                    end
                    else if (success_hit)
                    begin
                        success_run_next = '0;
                        scale_next       = rnd_scale;
                    end
                end
                POLICY_LINEAR_ADAPTIVE:
                begin
                    if (fail_hit)
                    begin
                        fail_run_next = '0;
                        scale_next    = rnd_scale;
                    end
                    else if (success_hit)
                    begin
                        success_run_next = '0;
                        if (!at_largest)
                        begin
                            scale_next = scale_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    // No policy, or an undefined code: the scale stays put.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg       <= '0;
            total_reg       <= '0;
            fail_run_reg    <= '0;
            success_run_reg <= '0;
        end
        else if (advance)
        begin
            scale_reg       <= scale_next;
            total_reg       <= total_next;
            fail_run_reg    <= fail_run_next;
            success_run_reg <= success_run_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    logic [SCALE_W-1:0] scale_out_reg;
    logic [BYTES_W-1:0] chunk_bytes_out_reg;
    logic [BYTES_W-1:0] credited_out_reg;
    logic [TOTAL_W-1:0] total_out_reg;
    logic               done_out_reg;
    logic               invalid_out_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            scale_out_reg       <= scale_next;
            chunk_bytes_out_reg <= MAX_CHUNK_BYTES >> scale_next;
            credited_out_reg    <= credited;
            total_out_reg       <= total_next;
            done_out_reg        <= total_next >= total_workload_reg;
            invalid_out_reg     <= invalid;
        end
    end

    assign out_valid        = out_valid_reg;
    assign scale_index      = scale_out_reg;
    assign next_chunk_bytes = chunk_bytes_out_reg;
    assign bytes_credited   = credited_out_reg;
    assign bytes_total      = total_out_reg;
    assign workload_done    = done_out_reg;
    assign invalid_policy   = invalid_out_reg;

endmodule
